// ----- design/bgc_pkg.sv -----
package bgc_pkg;

  // Width of the millisecond time base that elapsed times are taken modulo.
  localparam int TIME_BITS = 32;

  // Widths fixed by the register and field definitions.
  localparam int INTERVAL_W = 16;
  localparam int GESTURE_W  = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // Gesture codes.
  localparam logic [GESTURE_W-1:0] GESTURE_NONE   = 2'd0;
  localparam logic [GESTURE_W-1:0] GESTURE_SINGLE = 2'd1;
  localparam logic [GESTURE_W-1:0] GESTURE_DOUBLE = 2'd2;
  localparam logic [GESTURE_W-1:0] GESTURE_LONG   = 2'd3;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW    = 2'd2;

  // Reset values of the registers.
  localparam logic [INTERVAL_W-1:0] LONG_PRESS_RESET    = 16'd650;
  localparam logic [INTERVAL_W-1:0] DOUBLE_WINDOW_RESET = 16'd300;

  typedef struct packed {
    logic [INTERVAL_W-1:0] long_press_ms;
    logic [INTERVAL_W-1:0] double_window_ms;
    logic                  active_low;
  } bgc_cfg_t;

endpackage

// ----- design/bgc_core.sv -----
module bgc_core
  import bgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  bgc_cfg_t             cfg,
  input  logic                 accept,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 raw_level,
  output logic [GESTURE_W-1:0] gesture
);

  logic                 is_down_r, is_down_nxt;
  logic                 long_reported_r, long_reported_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic [TIME_BITS-1:0] release_time_r, release_time_nxt;
  logic [1:0]           click_count_r, click_count_nxt;

  logic                 pressed;
  logic [TIME_BITS-1:0] held_time;
  logic [TIME_BITS-1:0] quiet_time;
  logic [TIME_BITS-1:0] long_limit;
  logic [TIME_BITS-1:0] window_limit;

  assign pressed      = cfg.active_low ? ~raw_level : raw_level;
  assign long_limit   = {{(TIME_BITS-INTERVAL_W){1'b0}}, cfg.long_press_ms};
  assign window_limit = {{(TIME_BITS-INTERVAL_W){1'b0}}, cfg.double_window_ms};

  // Elapsed times use the edge-updated timestamps, so they wrap naturally.
  assign held_time  = now - press_time_nxt;
  assign quiet_time = now - release_time_nxt;

  always_comb begin
    is_down_nxt       = is_down_r;
    long_reported_nxt = long_reported_r;
    press_time_nxt    = press_time_r;
    release_time_nxt  = release_time_r;
    click_count_nxt   = click_count_r;
    gesture           = GESTURE_NONE;

    if (pressed && !is_down_r) begin
      is_down_nxt       = 1'b1;
      long_reported_nxt = 1'b0;
      press_time_nxt    = now;
    end else if (!pressed && is_down_r) begin
      is_down_nxt = 1'b0;
      if (!long_reported_r) begin
        if (click_count_r != 2'd3) begin
          click_count_nxt = click_count_r + 2'd1;
        end
        release_time_nxt = now;
      end
    end

    if (is_down_nxt && !long_reported_nxt && (held_time >= long_limit)) begin
      long_reported_nxt = 1'b1;
      click_count_nxt   = 2'd0;
      gesture           = GESTURE_LONG;
    end else if (!is_down_nxt && (click_count_nxt != 2'd0) &&
                 (quiet_time >= window_limit)) begin
      gesture         = (click_count_nxt >= 2'd2) ? GESTURE_DOUBLE : GESTURE_SINGLE;
      click_count_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_down_r       <= 1'b0;
      long_reported_r <= 1'b0;
      press_time_r    <= '0;
      release_time_r  <= '0;
      click_count_r   <= 2'd0;
    end else if (accept) begin
      is_down_r       <= is_down_nxt;
      long_reported_r <= long_reported_nxt;
      press_time_r    <= press_time_nxt;
      release_time_r  <= release_time_nxt;
      click_count_r   <= click_count_nxt;
    end
  end

endmodule

// ----- design/button_gesture_classifier.sv -----
// Button gesture classifier. Each request on the input channel carries a
// millisecond timestamp and the raw level of one button pin, and yields exactly
// one result request whose gesture is none, single click, double click or long
// press. The pin level is turned into a pressed flag by the active_low register.
// A hold that reaches long_press_ms reports a long press once, and its release
// counts no click. When no new press arrives for double_window_ms after the last
// counted release, the pending clicks are reported as a single click (one) or a
// double click (two or more; the count saturates at three). Elapsed times wrap
// modulo the 32-bit timestamp. The block takes one request per clock cycle
// while in_stall is low: the whole classification is a single pass of edge
// detection plus two wrapping subtract-and-compare paths, updating the state
// registers at the accept edge. A two-entry output buffer (out_* plus a skid
// entry) lets a new request be accepted while a result is still stalled;
// in_stall rises only when both entries hold results. Registers sit on an
// APB-style port at byte addresses 0x0 (long_press_ms), 0x4 (double_window_ms)
// and 0x8 (active_low), and should be written only while the block is idle.
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_time_ms,
  input  logic                  in_raw_level,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [GESTURE_W-1:0]  out_gesture
);

  // Configuration registers.
  bgc_cfg_t               cfg_r;
  logic                   cfg_write;
  logic [REG_IDX_W-1:0]   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms    <= LONG_PRESS_RESET;
      cfg_r.double_window_ms <= DOUBLE_WINDOW_RESET;
      cfg_r.active_low       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_LONG_PRESS:    cfg_r.long_press_ms    <= cfg_pwdata[INTERVAL_W-1:0];
        REG_DOUBLE_WINDOW: cfg_r.double_window_ms <= cfg_pwdata[INTERVAL_W-1:0];
        REG_ACTIVE_LOW:    cfg_r.active_low       <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads are combinational; unused addresses read as zero.
  always_comb begin
    case (cfg_idx)
      REG_LONG_PRESS:
        cfg_prdata = {{(CFG_DATA_W-INTERVAL_W){1'b0}}, cfg_r.long_press_ms};
      REG_DOUBLE_WINDOW:
        cfg_prdata = {{(CFG_DATA_W-INTERVAL_W){1'b0}}, cfg_r.double_window_ms};
      REG_ACTIVE_LOW:
        cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.active_low};
      default:
        cfg_prdata = '0;
    endcase
  end

  // Output buffer: a main result register plus a skid entry. The input is
  // stalled only while the skid entry is occupied.
  logic                 out_valid_r;
  logic [GESTURE_W-1:0] out_gesture_r;
  logic                 skid_valid_r;
  logic [GESTURE_W-1:0] skid_gesture_r;
  logic                 in_accept;
  logic                 out_pop;
  logic [GESTURE_W-1:0] gesture;

  assign in_stall    = skid_valid_r;
  assign in_accept   = in_valid && !skid_valid_r;
  assign out_pop     = out_valid_r && !out_stall;
  assign out_valid   = out_valid_r;
  assign out_gesture = out_gesture_r;

  // The 32-bit timestamp is narrowed or zero-extended to the time base width.
  bgc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (in_accept),
    .now       (TIME_BITS'(in_time_ms)),
    .raw_level (in_raw_level),
    .gesture   (gesture)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid_r) begin
        out_gesture_r <= skid_gesture_r;
        skid_valid_r  <= 1'b0;
      end else if (in_accept) begin
        out_gesture_r <= gesture;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_r) begin
        out_valid_r   <= 1'b1;
        out_gesture_r <= gesture;
      end else begin
        skid_valid_r   <= 1'b1;
        skid_gesture_r <= gesture;
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb
  import bgc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch without any handshake or register access before the run
  // is declared hung. The receiver hold-off below is the longest legal gap.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int NUM_PHASES      = 8;

  // One poll of the button: timestamp and raw pin level.
  typedef struct packed {
    logic [TIME_BITS-1:0] time_ms;
    logic                 level;
  } poll_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [31:0]           in_time_ms   = '0;
  logic                  in_raw_level = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [GESTURE_W-1:0]  out_gesture;

  button_gesture_classifier i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_time_ms  (in_time_ms),
    .in_raw_level(in_raw_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_gesture (out_gesture)
  );

  always #4 clk = ~clk;

  // Polls waiting to be offered, and the gestures the accepted polls must yield.
  poll_t                poll_q[$];
  logic [GESTURE_W-1:0] gesture_q[$];
  poll_t                next_poll;
  logic [GESTURE_W-1:0] want_gesture;

  // Idle and stall rates of the current phase, in percent.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // A request for a long receiver hold-off is a bump of hold_off_reqs; the
  // receiver process owns the countdown.
  int unsigned hold_off_reqs = 0;
  int unsigned hold_off_done = 0;
  int unsigned hold_off_left = 0;

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned polls_made   = 0;

  // Register copies kept in step with every write.
  logic [INTERVAL_W-1:0] cfg_long_ms    = LONG_PRESS_RESET;
  logic [INTERVAL_W-1:0] cfg_window_ms  = DOUBLE_WINDOW_RESET;
  logic                  cfg_active_low = 1'b0;

  // Gesture tracking state, starting out with the button released.
  logic                 btn_down  = 1'b0;
  logic                 long_seen = 1'b0;
  logic [TIME_BITS-1:0] press_ms   = '0;
  logic [TIME_BITS-1:0] release_ms = '0;
  logic [1:0]           clicks     = 2'd0;

  // Timestamp that the stimulus generator has reached.
  logic [TIME_BITS-1:0] gen_now = '0;

  // Advances the tracking state by one poll and returns the gesture it reports.
  // Edges come first, then the hold check, and only when no long press fired
  // in this poll, the check for an expired click window.
  function automatic logic [GESTURE_W-1:0] classify_poll(input logic [TIME_BITS-1:0] now,
                                                         input logic level);
    logic                 pressed;
    logic [GESTURE_W-1:0] found;
    pressed = level ^ cfg_active_low;
    found   = GESTURE_NONE;
    if (pressed && !btn_down) begin
      btn_down  = 1'b1;
      long_seen = 1'b0;
      press_ms  = now;
    end else if (!pressed && btn_down) begin
      btn_down = 1'b0;
      // The release that ends a reported long press is not a click.
      if (!long_seen) begin
        if (clicks != 2'd3) clicks = clicks + 2'd1;
        release_ms = now;
      end
    end
    // Differences are taken in the full timestamp width so that they wrap.
    if (btn_down && !long_seen && (now - press_ms) >= TIME_BITS'(cfg_long_ms)) begin
      long_seen = 1'b1;
      clicks    = 2'd0;
      found     = GESTURE_LONG;
    end else if (!btn_down && clicks != 2'd0 &&
                 (now - release_ms) >= TIME_BITS'(cfg_window_ms)) begin
      found  = (clicks >= 2'd2) ? GESTURE_DOUBLE : GESTURE_SINGLE;
      clicks = 2'd0;
    end
    return found;
  endfunction

  // Sender: a request stays on the port until it is taken; the decision to go
  // idle is made only once the port is free, so valid never follows stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (poll_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_poll = poll_q.pop_front();
        in_valid     <= 1'b1;
        in_time_ms   <= 32'(next_poll.time_ms);
        in_raw_level <= next_poll.level;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver and checker. An accepted poll is predicted before the result side
  // is checked, so the order holds even if a result came out in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        gesture_q.push_back(classify_poll(TIME_BITS'(in_time_ms), in_raw_level));
      end
      if (out_valid && !out_stall) begin
        if (gesture_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: gesture %0d arrived with none expected", $time, out_gesture);
          mismatches <= mismatches + 1;
        end else begin
          want_gesture = gesture_q.pop_front();
          if (out_gesture !== want_gesture) begin
            if (mismatches < 10)
              $display("%0t: gesture mismatch, expected %0d, got %0d",
                       $time, want_gesture, out_gesture);
            mismatches <= mismatches + 1;
          end
        end
      end
      // A hold-off keeps the receiver stalled long enough for the block to
      // fill its buffer and push back on the sender.
      if (hold_off_done != hold_off_reqs) begin
        hold_off_done <= hold_off_done + 1;
        hold_off_left <= HOLD_OFF_CYCLES;
        out_stall     <= 1'b1;
      end else if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        out_stall     <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: any handshake or register access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write: setup cycle, then access cycle until pready is seen.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LONG_PRESS:    cfg_long_ms    = value[INTERVAL_W-1:0];
      REG_DOUBLE_WINDOW: cfg_window_ms  = value[INTERVAL_W-1:0];
      REG_ACTIVE_LOW:    cfg_active_low = value[0];
      default: ;
    endcase
  endtask

  task automatic add_poll(input logic level);
    poll_q.push_back('{time_ms: gen_now, level: level});
    polls_made++;
  endtask

  task automatic poll_at(input logic [TIME_BITS-1:0] t, input logic level);
    gen_now = t;
    add_poll(level);
  endtask

  // Holds the button pressed or released for at least span milliseconds,
  // polling at random steps; the first poll lands on the edge itself.
  task automatic hold_button(input bit pressed, input int unsigned span);
    int unsigned spent;
    int unsigned step;
    spent = 0;
    do begin
      add_poll(pressed ^ cfg_active_low);
      step    = $urandom_range(0, span / 3 + 1);
      gen_now = gen_now + step;
      spent   = spent + step;
    end while (spent < span);
  endtask

  // Mostly click trains with holds and gaps around the thresholds, plus some
  // noise, polls that step back in time, and jumps to just below the wrap.
  task automatic make_gesture();
    int unsigned hold_max;
    int unsigned win;
    int unsigned kind;
    hold_max = 32'(cfg_long_ms);
    win      = 32'(cfg_window_ms);
    kind     = $urandom_range(0, 9);
    if (kind < 7) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) == 0 || hold_max == 0)
          hold_button(1'b1, $urandom_range(hold_max, 2 * hold_max + 2));
        else
          hold_button(1'b1, $urandom_range(0, hold_max - 1));
        hold_button(1'b0, $urandom_range(0, win + 1));
      end
      hold_button(1'b0, $urandom_range(win, 2 * win + 2));
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 3)) begin
        gen_now = $urandom;
        add_poll(1'($urandom_range(0, 1)));
      end
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) begin
        gen_now = gen_now - $urandom_range(0, hold_max / 2 + win / 2 + 1);
        add_poll(1'($urandom_range(0, 1)));
      end
    end else begin
      gen_now = '1 - $urandom_range(0, hold_max + 1);
    end
  endtask

  // Waits until the sender is empty and every expected gesture has arrived.
  task automatic wait_drained();
    do @(negedge clk); while (poll_q.size() != 0 || in_valid || gesture_q.size() != 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed polls under the reset settings (pressed is level one).
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    // Idle poll, then one click that is reported once the window has passed,
    // checked one millisecond before and exactly at the window.
    poll_at(32'd0, 1'b0);
    poll_at(32'd100, 1'b1);
    poll_at(32'd200, 1'b0);
    poll_at(32'd499, 1'b0);
    poll_at(32'd500, 1'b0);
    // Two clicks give a double click.
    poll_at(32'd600, 1'b1);
    poll_at(32'd650, 1'b0);
    poll_at(32'd700, 1'b1);
    poll_at(32'd750, 1'b0);
    poll_at(32'd1050, 1'b0);
    // Four clicks: the count saturates and still reports a double click.
    poll_at(32'd1100, 1'b1);
    poll_at(32'd1110, 1'b0);
    poll_at(32'd1120, 1'b1);
    poll_at(32'd1130, 1'b0);
    poll_at(32'd1140, 1'b1);
    poll_at(32'd1150, 1'b0);
    poll_at(32'd1160, 1'b1);
    poll_at(32'd1170, 1'b0);
    poll_at(32'd1470, 1'b0);
    // Long press reached exactly at the hold time, reported once; its release
    // counts no click, so nothing follows after the window.
    poll_at(32'd1500, 1'b1);
    poll_at(32'd2150, 1'b1);
    poll_at(32'd2200, 1'b1);
    poll_at(32'd2300, 1'b0);
    poll_at(32'd2700, 1'b0);
    // Long press measured across the timestamp wrap.
    poll_at(32'hFFFF_FF00, 1'b1);
    poll_at(32'h0000_0200, 1'b1);
    poll_at(32'h0000_0210, 1'b0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Phase zero keeps the reset settings; the rest cover both extremes,
      // zero thresholds and random small values with either polarity.
      case (p)
        0: ;
        1: begin
          write_reg(REG_LONG_PRESS, 32'd20);
          write_reg(REG_DOUBLE_WINDOW, 32'd10);
          write_reg(REG_ACTIVE_LOW, 32'd1);
        end
        2: begin
          write_reg(REG_LONG_PRESS, 32'd1);
          write_reg(REG_DOUBLE_WINDOW, 32'd1);
          write_reg(REG_ACTIVE_LOW, 32'd0);
        end
        3: begin
          write_reg(REG_LONG_PRESS, 32'd65535);
          write_reg(REG_DOUBLE_WINDOW, 32'd65535);
          write_reg(REG_ACTIVE_LOW, 32'd1);
        end
        4: begin
          write_reg(REG_LONG_PRESS, 32'd0);
          write_reg(REG_DOUBLE_WINDOW, 32'd0);
          write_reg(REG_ACTIVE_LOW, 32'd0);
        end
        default: begin
          write_reg(REG_LONG_PRESS, $urandom_range(1, 300));
          write_reg(REG_DOUBLE_WINDOW, $urandom_range(1, 300));
          write_reg(REG_ACTIVE_LOW, $urandom_range(0, 1));
        end
      endcase
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      while (polls_made < 27 + (p + 1) * 128) make_gesture();
      // With the sender running flat out, a long hold-off fills the block.
      if (p == 0) hold_off_reqs <= hold_off_reqs + 1;
      wait_drained();
    end

    // Every poll yields exactly one result; a short margin catches extras.
    repeat (10) @(negedge clk);
    if (gesture_q.size() != 0 && mismatches < 10) begin
      $display("%0d expected gestures never arrived", gesture_q.size());
    end
    if (mismatches == 0 && gesture_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- button_gesture_classifier.f -----
design/bgc_pkg.sv
design/bgc_core.sv
design/button_gesture_classifier.sv
tb/tb.sv
